/* rtl/lwe_plaintext_encode_decode_unit_assert.svh */
// Assertion macros for the RTL.
`ifndef LWE_PLAINTEXT_ENCODE_DECODE_UNIT_ASSERT_SVH
`define LWE_PLAINTEXT_ENCODE_DECODE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LWE_PED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define LWE_PED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lwe_ped_pkg.sv */
`timescale 1ns / 1ps

package lwe_ped_pkg;

  localparam int WordWidth        = 64;
  localparam int ResultLimit      = 16;
  localparam int MaxChunksDefault = 16;
  localparam int RegIndexWidth    = 3;

  localparam logic [5:0] MsgWidthMin   = 6'd1;
  localparam logic [5:0] MsgWidthMax   = 6'd62;
  localparam logic [4:0] ChunkWidthMin = 5'd1;
  localparam logic [4:0] ChunkWidthMax = 5'd30;
  localparam logic [5:0] BoolEncShift  = 6'd62;
  localparam logic [5:0] BoolDecWidth  = 6'd2;

  typedef enum logic [1:0] {
    MODE_BOOLEAN = 2'd0,
    MODE_NATIVE  = 2'd1,
    MODE_CHUNKED = 2'd2
  } mode_e;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic [RegIndexWidth-1:0] {
    REG_MODE          = 3'd0,
    REG_MESSAGE_WIDTH = 3'd1,
    REG_IS_SIGNED     = 3'd2,
    REG_CHUNK_WIDTH   = 3'd3,
    REG_CHUNK_COUNT   = 3'd4
  } reg_e;

  localparam mode_e      ModeReset         = MODE_NATIVE;
  localparam logic [5:0] MessageWidthReset = 6'd8;
  localparam logic       IsSignedReset     = 1'b0;
  localparam logic [4:0] ChunkWidthReset   = 5'd2;
  localparam logic [4:0] ChunkCountReset   = 5'd4;

  typedef struct packed {
    mode_e      mode;
    logic [5:0] message_width;
    logic       is_signed;
    logic [4:0] chunk_width;
    logic [4:0] chunk_count;
  } cfg_t;

endpackage

/* rtl/lwe_ped_if.sv */
`timescale 1ns / 1ps

interface lwe_ped_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] data_word;

  modport source (output valid, output opcode, output data_word, input ready);
  modport sink (input valid, input opcode, input data_word, output ready);
endinterface

interface lwe_ped_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_word;
  logic        last;

  modport source (output valid, output result_word, output last, input ready);
  modport sink (input valid, input result_word, input last, output ready);
endinterface

interface lwe_ped_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [lwe_ped_pkg::RegIndexWidth-1:0] reg_index;
  logic [63:0]                           wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

/* rtl/lwe_ped_datapath.sv */
`timescale 1ns / 1ps

module lwe_ped_datapath (
  input  lwe_ped_pkg::cfg_t cfg_i,
  input  logic              opcode_i,
  input  logic [63:0]       data_i,
  input  logic [63:0]       acc_i,
  input  logic [3:0]        chunk_idx_i,
  output logic [63:0]       result_word_o,
  output logic [63:0]       acc_sum_o
);

  function automatic logic [63:0] round_word(logic [63:0] word, logic [5:0] w);
    logic [63:0] t;
    logic [63:0] m;
    logic [6:0]  wp1;
    t   = word >> (6'd62 - w);
    wp1 = {1'b0, w} + 7'd1;
    m   = (64'd1 << wp1) - 64'd1;
    return ((t >> 1) + {63'd0, t[0]}) & m;
  endfunction

  logic [5:0]  w;
  logic [4:0]  cw;
  logic [63:0] mask;
  logic [63:0] native_dec;
  logic [63:0] chunk_val;
  logic [8:0]  pos;

  always_comb begin
    if (cfg_i.message_width < lwe_ped_pkg::MsgWidthMin) begin
      w = lwe_ped_pkg::MsgWidthMin;
    end else if (cfg_i.message_width > lwe_ped_pkg::MsgWidthMax) begin
      w = lwe_ped_pkg::MsgWidthMax;
    end else begin
      w = cfg_i.message_width;
    end
    if (cfg_i.chunk_width < lwe_ped_pkg::ChunkWidthMin) begin
      cw = lwe_ped_pkg::ChunkWidthMin;
    end else if (cfg_i.chunk_width > lwe_ped_pkg::ChunkWidthMax) begin
      cw = lwe_ped_pkg::ChunkWidthMax;
    end else begin
      cw = cfg_i.chunk_width;
    end
  end

  always_comb begin
    native_dec = round_word(data_i, w);
    if (cfg_i.is_signed && (native_dec >= (64'd1 << (w - 6'd1)))) begin
      native_dec = native_dec | ({64{1'b1}} << w);
    end
  end

  assign mask      = (64'd1 << cw) - 64'd1;
  assign chunk_val = round_word(data_i, {1'b0, cw}) & mask;
  assign pos       = 9'(cw) * 9'(chunk_idx_i);
  assign acc_sum_o = (pos < 9'd64) ? acc_i + (chunk_val << pos[5:0]) : acc_i;

  always_comb begin
    case (cfg_i.mode)
      lwe_ped_pkg::MODE_BOOLEAN: begin
        if (opcode_i == lwe_ped_pkg::OP_ENCODE) begin
          result_word_o = data_i << lwe_ped_pkg::BoolEncShift;
        end else begin
          result_word_o = round_word(data_i, lwe_ped_pkg::BoolDecWidth);
        end
      end
      lwe_ped_pkg::MODE_NATIVE: begin
        if (opcode_i == lwe_ped_pkg::OP_ENCODE) begin
          result_word_o = data_i << (6'd63 - w);
        end else begin
          result_word_o = native_dec;
        end
      end
      lwe_ped_pkg::MODE_CHUNKED: begin
        if (opcode_i == lwe_ped_pkg::OP_ENCODE) begin
          result_word_o = (data_i & mask) << (6'd63 - {1'b0, cw});
        end else begin
          result_word_o = acc_sum_o;
        end
      end
      default: begin
        result_word_o = '0;
      end
    endcase
  end

endmodule

/* rtl/lwe_plaintext_encode_decode_unit.sv */
`timescale 1ns / 1ps

// Torus plaintext encoder/decoder with padding bit. An accepted beat is held in
// an input register, worked on by one pass of shift, round and add logic, and
// its result lands in an output register once that register is free. Boolean
// and native encode/decode, and chunked decode, finish an item in one pass, so a
// new item enters every cycle while the output side keeps up. Chunked encode
// holds its item in the input register until its last chunk is sent, and sends
// one result beat per cycle while the output side keeps up, least significant
// chunk first; the single output register sets that rate. Non-final chunked decodes
// and items in the unused mode produce no result beat. Any configuration write to
// a known register clears a partial chunked decode.
module lwe_plaintext_encode_decode_unit #(
  parameter int MAX_CHUNKS = lwe_ped_pkg::MaxChunksDefault
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  lwe_ped_in_if.sink           in_if,
  lwe_ped_out_if.source        out_if,
  lwe_ped_cfg_if.sink          cfg_if
);

  localparam int CountLimit =
    (MAX_CHUNKS < lwe_ped_pkg::ResultLimit) ? MAX_CHUNKS : lwe_ped_pkg::ResultLimit;

  lwe_ped_pkg::cfg_t cfg_q;

  logic        s1_valid_q;
  logic        s1_op_q;
  logic [63:0] s1_data_q;
  logic [3:0]  s1_beat_q;
  logic [63:0] acc_q;
  logic [3:0]  idx_q;
  logic        out_valid_q;
  logic [63:0] out_word_q;
  logic        out_last_q;

  logic [4:0]  cc;
  logic [4:0]  eff_cnt;
  logic        is_chunk_enc;
  logic        final_beat;
  logic        dec_last;
  logic        emits;
  logic        out_free;
  logic        s1_fire;
  logic        s1_done;
  logic        in_accept;
  logic        cfg_known;
  logic [4:0]  shift_cw;
  logic [63:0] dp_word;
  logic [63:0] dp_acc_sum;

  assign cc      = (cfg_q.chunk_count == 5'd0) ? 5'd1 : cfg_q.chunk_count;
  assign eff_cnt = (cc > 5'(CountLimit)) ? 5'(CountLimit) : cc;

  assign is_chunk_enc = (cfg_q.mode == lwe_ped_pkg::MODE_CHUNKED) &&
                        (s1_op_q == lwe_ped_pkg::OP_ENCODE);
  assign final_beat   = !is_chunk_enc || (({1'b0, s1_beat_q} + 5'd1) == eff_cnt);
  assign dec_last     = (({1'b0, idx_q} + 5'd1) >= eff_cnt);

  always_comb begin
    case (cfg_q.mode)
      lwe_ped_pkg::MODE_BOOLEAN: emits = 1'b1;
      lwe_ped_pkg::MODE_NATIVE:  emits = 1'b1;
      lwe_ped_pkg::MODE_CHUNKED: emits = is_chunk_enc || dec_last;
      default:                   emits = 1'b0;
    endcase
  end

  assign out_free  = !out_valid_q || out_if.ready;
  assign s1_fire   = s1_valid_q && out_free;
  assign s1_done   = s1_fire && final_beat;
  assign in_if.ready = !s1_valid_q || s1_done;
  assign in_accept = in_if.valid && in_if.ready;

  assign cfg_if.ready = 1'b1;
  assign cfg_known    = (cfg_if.reg_index == lwe_ped_pkg::REG_MODE) ||
                        (cfg_if.reg_index == lwe_ped_pkg::REG_MESSAGE_WIDTH) ||
                        (cfg_if.reg_index == lwe_ped_pkg::REG_IS_SIGNED) ||
                        (cfg_if.reg_index == lwe_ped_pkg::REG_CHUNK_WIDTH) ||
                        (cfg_if.reg_index == lwe_ped_pkg::REG_CHUNK_COUNT);

  assign shift_cw = (cfg_q.chunk_width < lwe_ped_pkg::ChunkWidthMin) ?
                    lwe_ped_pkg::ChunkWidthMin :
                    (cfg_q.chunk_width > lwe_ped_pkg::ChunkWidthMax) ?
                    lwe_ped_pkg::ChunkWidthMax : cfg_q.chunk_width;

  lwe_ped_datapath u_datapath (
    .cfg_i        (cfg_q),
    .opcode_i     (s1_op_q),
    .data_i       (s1_data_q),
    .acc_i        (acc_q),
    .chunk_idx_i  (idx_q),
    .result_word_o(dp_word),
    .acc_sum_o    (dp_acc_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= lwe_ped_pkg::ModeReset;
      cfg_q.message_width <= lwe_ped_pkg::MessageWidthReset;
      cfg_q.is_signed     <= lwe_ped_pkg::IsSignedReset;
      cfg_q.chunk_width   <= lwe_ped_pkg::ChunkWidthReset;
      cfg_q.chunk_count   <= lwe_ped_pkg::ChunkCountReset;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.reg_index)
        lwe_ped_pkg::REG_MODE:
          cfg_q.mode <= lwe_ped_pkg::mode_e'(cfg_if.wdata[1:0]);
        lwe_ped_pkg::REG_MESSAGE_WIDTH: cfg_q.message_width <= cfg_if.wdata[5:0];
        lwe_ped_pkg::REG_IS_SIGNED:     cfg_q.is_signed     <= cfg_if.wdata[0];
        lwe_ped_pkg::REG_CHUNK_WIDTH:   cfg_q.chunk_width   <= cfg_if.wdata[4:0];
        lwe_ped_pkg::REG_CHUNK_COUNT:   cfg_q.chunk_count   <= cfg_if.wdata[4:0];
        default: ;
      endcase
    end
  end

  // Input register: load a new beat, or step through chunks of an encode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_beat_q  <= 4'd0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
      s1_beat_q  <= 4'd0;
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
    end else if (s1_fire) begin
      s1_beat_q <= s1_beat_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q   <= in_if.opcode;
      s1_data_q <= in_if.data_word;
    end else if (s1_fire && !final_beat) begin
      s1_data_q <= s1_data_q >> shift_cw;
    end
  end

  // Partial chunked decode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      idx_q <= 4'd0;
    end else if (cfg_if.valid && cfg_if.ready && cfg_known) begin
      acc_q <= '0;
      idx_q <= 4'd0;
    end else if (s1_fire && (cfg_q.mode == lwe_ped_pkg::MODE_CHUNKED) &&
                 (s1_op_q == lwe_ped_pkg::OP_DECODE)) begin
      if (dec_last) begin
        acc_q <= '0;
        idx_q <= 4'd0;
      end else begin
        acc_q <= dp_acc_sum;
        idx_q <= idx_q + 4'd1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && emits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_word_q <= dp_word;
      out_last_q <= final_beat;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.result_word = out_word_q;
  assign out_if.last        = out_last_q;

`include "lwe_plaintext_encode_decode_unit_assert.svh"

  `LWE_PED_ASSERT_NOW(a_idx_in_range, 1'b1, ({1'b0, idx_q} < eff_cnt),
                      "decode index past count")
  `LWE_PED_ASSERT_NOW(a_beat_in_range, s1_valid_q && is_chunk_enc,
                      ({1'b0, s1_beat_q} < eff_cnt), "encode chunk past count")
  `LWE_PED_ASSERT_NOW(a_nonlast_chunked, out_valid_q && !out_last_q,
                      (cfg_q.mode == lwe_ped_pkg::MODE_CHUNKED),
                      "non-final beat outside chunked mode")
  `LWE_PED_ASSERT_NEXT(a_cfg_clears, cfg_if.valid && cfg_known,
                       (idx_q == 4'd0) && (acc_q == 64'd0),
                       "register write left partial decode")

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import lwe_ped_pkg::*;

  localparam int MaxChunks    = MaxChunksDefault;
  localparam int SettleCycles = 6;
  localparam int QuietLimit   = 2000;
  localparam int RandomItems  = 400;

  localparam logic [1:0]               MODE_UNUSED = 2'd3;
  localparam logic [RegIndexWidth-1:0] REG_UNUSED  = 3'd7;

  typedef struct packed {
    logic [63:0] word;
    logic        last;
  } word_beat_t;

  typedef struct {
    bit                       is_reg;
    logic [RegIndexWidth-1:0] idx;
    op_e                      op;
    logic [63:0]              data;
    bit                       typed;
    logic [63:0]              want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  lwe_ped_in_if  in_if ();
  lwe_ped_out_if out_if ();
  lwe_ped_cfg_if cfg_if ();

  lwe_plaintext_encode_decode_unit #(
    .MAX_CHUNKS(MaxChunks)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  logic [1:0]  cfg_mode;
  logic [5:0]  cfg_msg_width;
  logic        cfg_signed;
  logic [4:0]  cfg_chunk_width;
  logic [4:0]  cfg_chunk_count;
  logic [63:0] dec_sum;
  logic [3:0]  dec_pos;

  word_beat_t pending_words[$];
  word_beat_t step_words[$];
  stim_row_t  dir_rows[$];
  word_beat_t head;

  int  errors;
  int  quiet;
  int  sink_hold;
  bit  src_calm;
  bit  sink_calm;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int eff_msg_width();
    if (cfg_msg_width < MsgWidthMin) return MsgWidthMin;
    if (cfg_msg_width > MsgWidthMax) return MsgWidthMax;
    return cfg_msg_width;
  endfunction

  function automatic int eff_chunk_width();
    if (cfg_chunk_width < ChunkWidthMin) return ChunkWidthMin;
    if (cfg_chunk_width > ChunkWidthMax) return ChunkWidthMax;
    return cfg_chunk_width;
  endfunction

  function automatic int eff_chunk_count();
    int c;
    int lim;
    c = (cfg_chunk_count == 0) ? 1 : cfg_chunk_count;
    lim = (MaxChunks < ResultLimit) ? MaxChunks : ResultLimit;
    if (lim < 1) lim = 1;
    return (c > lim) ? lim : c;
  endfunction

  function automatic logic [63:0] round_to(input logic [63:0] word, input int w);
    logic [63:0] t;
    logic [63:0] m;
    t = word >> (62 - w);
    m = (64'd1 << (w + 1)) - 64'd1;
    return ((t >> 1) + {63'd0, t[0]}) & m;
  endfunction

  function automatic logic [63:0] make_word(input int w);
    logic [63:0] base;
    logic [63:0] noise;
    base = {$urandom, $urandom} << (63 - w);
    noise = {$urandom, $urandom} >> $urandom_range(w + 1, 63);
    return $urandom_range(0, 1) ? base + noise : base - noise;
  endfunction

  function automatic logic [63:0] pick_reg_value(input logic [RegIndexWidth-1:0] idx);
    logic [63:0] hi;
    int          r;
    int          v;
    hi = $urandom_range(0, 1) ? ({$urandom, $urandom} << 6) : 64'd0;
    r = $urandom_range(0, 99);
    case (idx)
      REG_MODE: begin
        v = (r < 20) ? int'(MODE_BOOLEAN) : (r < 50) ? int'(MODE_NATIVE) :
            (r < 94) ? int'(MODE_CHUNKED) : int'(MODE_UNUSED);
      end
      REG_MESSAGE_WIDTH: begin
        v = (r < 10) ? ($urandom_range(0, 1) ? 0 : 63) : $urandom_range(1, 62);
      end
      REG_IS_SIGNED: begin
        v = (r < 50) ? 1 : 0;
      end
      REG_CHUNK_WIDTH: begin
        v = (r < 5) ? 0 : (r < 10) ? 31 : (r < 25) ? $urandom_range(20, 30) :
            $urandom_range(1, 8);
      end
      REG_CHUNK_COUNT: begin
        v = (r < 4) ? 0 : (r < 10) ? $urandom_range(17, 31) : (r < 22) ? 16 :
            $urandom_range(1, 6);
      end
      default: begin
        v = $urandom_range(0, 63);
      end
    endcase
    return hi | 64'(v);
  endfunction

  task automatic apply_reg(input logic [RegIndexWidth-1:0] idx, input logic [63:0] wdata);
    case (idx)
      REG_MODE:          cfg_mode = wdata[1:0];
      REG_MESSAGE_WIDTH: cfg_msg_width = wdata[5:0];
      REG_IS_SIGNED:     cfg_signed = wdata[0];
      REG_CHUNK_WIDTH:   cfg_chunk_width = wdata[4:0];
      REG_CHUNK_COUNT:   cfg_chunk_count = wdata[4:0];
      default:           return;
    endcase
    dec_sum = '0;
    dec_pos = '0;
  endtask

  task automatic add_step(input logic [63:0] word, input logic last);
    step_words.insert(step_words.size(), '{word: word, last: last});
  endtask

  task automatic predict_words(input op_e op, input logic [63:0] data);
    int          w;
    int          cnt;
    int          pos;
    logic [63:0] v;
    logic [63:0] mask;
    logic [63:0] chunk;
    step_words.delete();
    case (cfg_mode)
      MODE_BOOLEAN: begin
        if (op == OP_ENCODE) begin
          add_step(data << BoolEncShift, 1'b1);
        end else begin
          add_step(round_to(data, BoolDecWidth), 1'b1);
        end
      end
      MODE_NATIVE: begin
        w = eff_msg_width();
        if (op == OP_ENCODE) begin
          add_step(data << (63 - w), 1'b1);
        end else begin
          v = round_to(data, w);
          if (cfg_signed && v >= (64'd1 << (w - 1))) v |= ~64'd0 << w;
          add_step(v, 1'b1);
        end
      end
      MODE_CHUNKED: begin
        w = eff_chunk_width();
        cnt = eff_chunk_count();
        mask = (64'd1 << w) - 64'd1;
        if (op == OP_ENCODE) begin
          v = data;
          for (int k = 0; k < cnt; k++) begin
            add_step((v & mask) << (63 - w), (k + 1 == cnt));
            v = v >> w;
          end
        end else begin
          chunk = round_to(data, w) & mask;
          pos = w * int'(dec_pos);
          if (pos < 64) dec_sum = dec_sum + (chunk << pos);
          if (int'(dec_pos) + 1 >= cnt) begin
            add_step(dec_sum, 1'b1);
            dec_sum = '0;
            dec_pos = '0;
          end else begin
            dec_pos = dec_pos + 4'd1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [RegIndexWidth-1:0] idx, input logic [63:0] wdata);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= wdata;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    apply_reg(idx, wdata);
  endtask

  task automatic send_beat(input op_e op, input logic [63:0] data, input bit typed,
                           input logic [63:0] want);
    int gap;
    gap = pick_gap(src_calm);
    cfg_if.valid <= 1'b0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.opcode    <= op;
    in_if.data_word <= data;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_words(op, data);
    if (typed) begin
      pending_words.insert(pending_words.size(), '{word: want, last: 1'b1});
    end else begin
      foreach (step_words[i]) pending_words.insert(pending_words.size(), step_words[i]);
    end
  endtask

  task automatic add_reg(input logic [RegIndexWidth-1:0] idx, input logic [63:0] wdata);
    dir_rows.insert(dir_rows.size(), '{1'b1, idx, OP_ENCODE, wdata, 1'b0, 64'd0});
  endtask

  task automatic add_op(input op_e op, input logic [63:0] data);
    dir_rows.insert(dir_rows.size(), '{1'b0, REG_MODE, op, data, 1'b0, 64'd0});
  endtask

  task automatic add_chk(input op_e op, input logic [63:0] data, input logic [63:0] want);
    dir_rows.insert(dir_rows.size(), '{1'b0, REG_MODE, op, data, 1'b1, want});
  endtask

  initial out_if.ready = 1'b0;

  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      out_if.ready <= 1'b0;
      sink_hold    <= sink_hold - 1;
    end else begin
      out_if.ready <= 1'b1;
      sink_hold    <= pick_gap(sink_calm);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected beat: result_word %h last %b", out_if.result_word, out_if.last);
        errors++;
      end else begin
        head = pending_words.pop_front();
        if (out_if.result_word !== head.word) begin
          $error("result_word: expected %h, actual %h", head.word, out_if.result_word);
          errors++;
        end
        if (out_if.last !== head.last) begin
          $error("last: expected %b, actual %b", head.last, out_if.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QuietLimit) begin
      $display("lwe_plaintext_encode_decode_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int                       done_items;
    int                       n;
    int                       w;
    int                       cnt;
    op_e                      op;
    logic [63:0]              d;
    logic [RegIndexWidth-1:0] ri;

    errors    = 0;
    quiet     = 0;
    sink_hold = 0;
    src_calm  = 1'b0;
    sink_calm = 1'b0;
    done_items = 0;

    cfg_mode        = ModeReset;
    cfg_msg_width   = MessageWidthReset;
    cfg_signed      = IsSignedReset;
    cfg_chunk_width = ChunkWidthReset;
    cfg_chunk_count = ChunkCountReset;
    dec_sum         = '0;
    dec_pos         = '0;

    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_ENCODE;
    in_if.data_word  = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = REG_MODE;
    cfg_if.wdata     = '0;

    add_chk(OP_ENCODE, 64'd0, 64'd0);
    add_chk(OP_ENCODE, ~64'd0, 64'hFF80_0000_0000_0000);
    add_chk(OP_DECODE, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0100);
    add_chk(OP_DECODE, ~64'd0, 64'd0);
    add_reg(REG_IS_SIGNED, 64'd1);
    add_chk(OP_DECODE, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FF00);
    add_reg(REG_MESSAGE_WIDTH, 64'd62);
    add_chk(OP_ENCODE, ~64'd0, 64'hFFFF_FFFF_FFFF_FFFE);
    add_chk(OP_DECODE, ~64'd0, 64'd0);
    add_reg(REG_MESSAGE_WIDTH, 64'd0);
    add_chk(OP_ENCODE, 64'd1, 64'h4000_0000_0000_0000);
    add_chk(OP_DECODE, 64'hC000_0000_0000_0000, ~64'd0);
    add_reg(REG_MESSAGE_WIDTH, 64'd63);
    add_chk(OP_ENCODE, 64'd5, 64'd10);
    add_reg(REG_MODE, 64'(MODE_BOOLEAN));
    add_chk(OP_ENCODE, 64'd3, 64'hC000_0000_0000_0000);
    add_chk(OP_DECODE, 64'h1000_0000_0000_0000, 64'd1);
    add_chk(OP_DECODE, ~64'd0, 64'd0);
    add_reg(REG_MODE, 64'(MODE_UNUSED));
    add_op(OP_ENCODE, ~64'd0);
    add_op(OP_DECODE, ~64'd0);
    add_reg(REG_MODE, 64'(MODE_CHUNKED));
    add_op(OP_ENCODE, 64'hE4);
    add_op(OP_DECODE, 64'h2000_0000_0000_0000);
    add_op(OP_DECODE, 64'h6000_0000_0000_0000);
    add_op(OP_DECODE, 64'h3FFF_FFFF_FFFF_FFFF);
    add_op(OP_DECODE, 64'h5000_0000_0000_0000);
    add_reg(REG_CHUNK_WIDTH, 64'd30);
    add_reg(REG_CHUNK_COUNT, 64'd31);
    add_op(OP_ENCODE, ~64'd0);
    add_reg(REG_CHUNK_WIDTH, 64'd0);
    add_reg(REG_CHUNK_COUNT, 64'd0);
    add_chk(OP_DECODE, 64'h4000_0000_0000_0000, 64'd1);
    add_reg(REG_CHUNK_WIDTH, 64'd31);
    add_reg(REG_CHUNK_COUNT, 64'hFFFF_FFFF_FFFF_FFE2);
    add_op(OP_DECODE, 64'h1234_5678_9ABC_DEF0);
    add_reg(REG_UNUSED, ~64'd0);
    add_op(OP_DECODE, 64'h7FFF_FFFF_0000_0000);
    add_op(OP_DECODE, 64'h0F0F_0F0F_0F0F_0F0F);
    add_reg(REG_CHUNK_COUNT, 64'd2);
    add_op(OP_DECODE, 64'hA5A5_5A5A_C3C3_3C3C);
    add_op(OP_DECODE, 64'hFFFF_FFFF_FFFF_FFFF);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_beat(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    while (done_items < RandomItems) begin
      drain();
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i <= int'(REG_CHUNK_COUNT); i++) begin
        ri = RegIndexWidth'(i);
        if ($urandom_range(0, 3) != 0) write_reg(ri, pick_reg_value(ri));
      end
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
      n = (cfg_mode == MODE_UNUSED) ? 6 : 30;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 49) == 0) begin
          drain();
          ri = RegIndexWidth'($urandom_range(0, int'(REG_CHUNK_COUNT)));
          write_reg(ri, pick_reg_value(ri));
        end
        if (cfg_mode == MODE_CHUNKED && $urandom_range(0, 2) != 0) begin
          w = eff_chunk_width();
          cnt = eff_chunk_count() - int'(dec_pos);
          for (int j = 0; j < cnt; j++) begin
            send_beat(OP_DECODE, make_word(w), 1'b0, 64'd0);
            done_items++;
          end
        end else begin
          op = op_e'($urandom_range(0, 1));
          if (op == OP_ENCODE) begin
            case ($urandom_range(0, 2))
              0:       d = {$urandom, $urandom};
              1:       d = 64'($urandom_range(0, 255));
              default: d = ~64'd0 >> $urandom_range(0, 63);
            endcase
          end else begin
            w = (cfg_mode == MODE_NATIVE) ? eff_msg_width() :
                (cfg_mode == MODE_CHUNKED) ? eff_chunk_width() : int'(BoolDecWidth);
            d = $urandom_range(0, 1) ? make_word(w) : {$urandom, $urandom};
          end
          send_beat(op, d, 1'b0, 64'd0);
          if (cfg_mode != MODE_UNUSED) done_items++;
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("lwe_plaintext_encode_decode_unit regression: pass");
    end else begin
      $display("lwe_plaintext_encode_decode_unit regression: fail");
    end
    $finish;
  end

endmodule
